@@ rtl/core/arc_segment_generator_top_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the arc segment generator
// Concurrent checks on clk_i, disabled while rst_ni is low; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef ARC_SEGMENT_GENERATOR_TOP_MACROS_SVH
`define ARC_SEGMENT_GENERATOR_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Check that a property holds at every clock edge outside reset.
`define ASG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Check that a condition never occurs outside reset.
`define ASG_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define ASG_ASSERT(lbl, prop, msg)
`define ASG_NEVER(lbl, expr, msg)
`endif

`endif

@@ rtl/core/asg_pkg.sv @@
// ----------------------------------------------------------------------------
// Arc segment generator package
// Shared constants, item types and small arithmetic helpers.
// ----------------------------------------------------------------------------
package asg_pkg;

  localparam int unsigned ARC_POINTS = 16;
  localparam int unsigned SEG_DEN    = ARC_POINTS - 1;
  localparam int unsigned IDX_W      = $clog2(ARC_POINTS);
  localparam int unsigned REM_W      = $clog2(SEG_DEN);

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned IN_W    = 9 * WORD_W;
  localparam int unsigned OUT_W   = 8 * WORD_W;

  // Angles in Q16.16 degrees, reduced into [0,360)
  localparam int unsigned ANG_W   = 25;
  localparam int unsigned RES_W   = 23;
  localparam logic [ANG_W-1:0] DEG360_A = 25'd23592960;
  localparam logic [ANG_W-1:0] DEG90_A  = 25'd5898240;
  localparam logic [ANG_W-1:0] DEG180_A = 25'd11796480;
  localparam logic [ANG_W-1:0] DEG270_A = 25'd17694720;
  localparam logic [33:0]      DEG360_W = 34'd23592960;
  // 365 full turns: lifts any folded start angle above zero
  localparam logic [33:0]      FOLD_BIAS = 34'd8611430400;

  // 360 degrees in Q16.16 is 45 * 2^19
  localparam int unsigned MOD_SHIFT  = 19;
  localparam int unsigned MOD_DIV    = 45;
  localparam int unsigned MAG_W      = 36;
  localparam int unsigned MAG_DIGITS = MAG_W / 4;
  localparam int unsigned MOD_DIGITS = 4;
  localparam int unsigned CALC_STEPS = MAG_DIGITS + MOD_DIGITS;
  localparam int unsigned STEP_W     = $clog2(CALC_STEPS);
  localparam logic [9:0]  SEG_DEN_V  = 10'(SEG_DEN);
  localparam logic [9:0]  MOD_DIV_V  = 10'(MOD_DIV);

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam int unsigned CORDIC_ITERS = 24;
  localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_e;

  typedef struct packed {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] cz;
    logic [31:0]        radius;
    logic [31:0]        color;
    logic [31:0]        param;
    logic [31:0]        flag;
  } req_t;

  typedef struct packed {
    req_t             req;
    logic [ANG_W-1:0] start_ang;
    logic [ANG_W-1:0] step_ang;
    logic [REM_W-1:0] step_rem;
    logic             neg;
  } job_t;

  typedef struct packed {
    req_t             req;
    logic [IDX_W-1:0] idx;
  } meta_t;

  typedef struct packed {
    logic [3:0] q;
    logic [9:0] r;
  } digit_t;

  // One radix-16 long-division step: v = {remainder, next digit}
  function automatic digit_t div_digit(input logic [9:0] v, input logic [9:0] dv);
    digit_t      res;
    logic [12:0] acc;
    logic [12:0] sub;
    acc   = {3'b000, v};
    res.q = '0;
    for (int k = 3; k >= 0; k--) begin
      sub = {3'b000, dv} << k;
      if (acc >= sub) begin
        acc      = acc - sub;
        res.q[k] = 1'b1;
      end
    end
    res.r = acc[9:0];
    return res;
  endfunction

  // Arctangent of 2^-k in Q8.24 degrees
  function automatic logic signed [31:0] atan_q24(input int unsigned k);
    logic signed [31:0] a;
    case (k)
      0:  a = 32'sd754974720;
      1:  a = 32'sd445687602;
      2:  a = 32'sd235489088;
      3:  a = 32'sd119537938;
      4:  a = 32'sd60000934;
      5:  a = 32'sd30029717;
      6:  a = 32'sd15018523;
      7:  a = 32'sd7509720;
      8:  a = 32'sd3754917;
      9:  a = 32'sd1877466;
      10: a = 32'sd938734;
      11: a = 32'sd469367;
      12: a = 32'sd234684;
      13: a = 32'sd117342;
      14: a = 32'sd58671;
      15: a = 32'sd29335;
      16: a = 32'sd14668;
      17: a = 32'sd7334;
      18: a = 32'sd3667;
      19: a = 32'sd1833;
      20: a = 32'sd917;
      21: a = 32'sd458;
      22: a = 32'sd229;
      23: a = 32'sd115;
      default: a = 32'sd0;
    endcase
    return a;
  endfunction

endpackage

@@ rtl/core/asg_front.sv @@
// ----------------------------------------------------------------------------
// Arc segment generator front end
// Accepts a request, folds the sweep and precomputes reduced start and step.
// ----------------------------------------------------------------------------
module asg_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_tvalid_i,
  output logic                        s_tready_o,
  input  logic [asg_pkg::IN_W-1:0]    s_tdata_i,
  output logic                        job_valid_o,
  input  logic                        job_ready_i,
  output asg_pkg::job_t               job_o
);
  import asg_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_PUSH
  } front_state_e;

  front_state_e      state_q;
  logic [STEP_W-1:0] step_q;

  req_t              req_q;
  logic              neg_q;
  logic [MAG_W-1:0]  mag_q;
  logic [MAG_W-1:0]  quo_q;
  logic [REM_W-1:0]  rem_q;
  logic [15:0]       ssrc_q;
  logic [5:0]        smod_q;
  logic [5:0]        dmod_q;
  logic [MOD_SHIFT-1:0] slow_q;
  logic [MOD_SHIFT-1:0] dlow_q;

  logic               accept;
  logic signed [31:0] start_w;
  logic signed [31:0] end_w;
  logic [33:0]        diff0;
  logic [33:0]        start_f;
  logic [33:0]        diff_f;
  logic [33:0]        mag_w;
  logic [33:0]        lift;
  digit_t             ddig;
  digit_t             sdig;
  digit_t             qdig;

  assign s_tready_o  = (state_q == ST_IDLE);
  assign job_valid_o = (state_q == ST_PUSH);
  assign accept      = s_tvalid_i && s_tready_o;

  always_comb begin
    start_w = s_tdata_i[159:128];
    end_w   = s_tdata_i[191:160];
    diff0   = {{2{end_w[31]}}, end_w} - {{2{start_w[31]}}, start_w};
    // fold once by a full turn when the sweep runs backward
    if (diff0[33]) begin
      start_f = {{2{start_w[31]}}, start_w} - DEG360_W;
      diff_f  = diff0 + DEG360_W;
    end else begin
      start_f = {{2{start_w[31]}}, start_w};
      diff_f  = diff0;
    end
    mag_w = diff_f[33] ? (34'd0 - diff_f) : diff_f;
    lift  = start_f + FOLD_BIAS;
    ddig  = div_digit(10'({rem_q, mag_q[MAG_W-1 -: 4]}), SEG_DEN_V);
    sdig  = div_digit({smod_q, ssrc_q[15:12]}, MOD_DIV_V);
    qdig  = div_digit({dmod_q, quo_q[MOD_SHIFT+15 -: 4]}, MOD_DIV_V);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            state_q <= ST_CALC;
            step_q  <= '0;
          end
        end
        ST_CALC: begin
          if (step_q == STEP_W'(CALC_STEPS - 1)) begin
            state_q <= ST_PUSH;
          end
          step_q <= step_q + 1'b1;
        end
        ST_PUSH: begin
          if (job_ready_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Quotient of |diff| by the segment count, then its modulo 45*2^19; start reduced alongside
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q.cx     <= s_tdata_i[31:0];
      req_q.cy     <= s_tdata_i[63:32];
      req_q.cz     <= s_tdata_i[95:64];
      req_q.radius <= s_tdata_i[127:96];
      req_q.color  <= s_tdata_i[223:192];
      req_q.param  <= s_tdata_i[255:224];
      req_q.flag   <= s_tdata_i[287:256];
      neg_q        <= diff_f[33];
      mag_q        <= MAG_W'(mag_w);
      quo_q        <= '0;
      rem_q        <= '0;
      ssrc_q       <= {1'b0, lift[33:MOD_SHIFT]};
      slow_q       <= lift[MOD_SHIFT-1:0];
      smod_q       <= '0;
      dmod_q       <= '0;
    end else if (state_q == ST_CALC) begin
      if (step_q < STEP_W'(MAG_DIGITS)) begin
        quo_q <= {quo_q[MAG_W-5:0], ddig.q};
        rem_q <= ddig.r[REM_W-1:0];
        mag_q <= mag_q << 4;
      end else begin
        if (step_q == STEP_W'(MAG_DIGITS)) begin
          dlow_q <= quo_q[MOD_SHIFT-1:0];
        end
        dmod_q <= qdig.r[5:0];
        quo_q  <= quo_q << 4;
      end
      if (step_q < STEP_W'(MOD_DIGITS)) begin
        smod_q <= sdig.r[5:0];
        ssrc_q <= ssrc_q << 4;
      end
    end
  end

  always_comb begin
    job_o.req       = req_q;
    job_o.start_ang = {smod_q, slow_q};
    job_o.step_ang  = {dmod_q, dlow_q};
    job_o.step_rem  = rem_q;
    job_o.neg       = neg_q;
  end

endmodule

@@ rtl/core/asg_queue.sv @@
// ----------------------------------------------------------------------------
// Arc segment generator job queue
// Short FIFO between the front end and the sweep.
// ----------------------------------------------------------------------------
module asg_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  asg_pkg::job_t  push_job_i,
  output logic           pop_valid_o,
  input  logic           pop_i,
  output asg_pkg::job_t  pop_job_o
);
  import asg_pkg::*;

  job_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_q;
  logic [QPTR_W-1:0] rptr_q;
  logic [QPTR_W:0]   count_q;
  logic              do_push;
  logic              do_pop;

  assign push_ready_o = (count_q != (QPTR_W+1)'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;
  assign pop_job_o    = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= rptr_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_job_i;
    end
  end

endmodule

@@ rtl/core/asg_sweep.sv @@
// ----------------------------------------------------------------------------
// Arc segment generator sweep
// Steps the reduced angle once per point and splits it into quadrant and residue.
// ----------------------------------------------------------------------------
`include "arc_segment_generator_top_macros.svh"

module asg_sweep (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            ce_i,
  input  logic            job_valid_i,
  input  asg_pkg::job_t   job_i,
  output logic            job_pop_o,
  output logic            pt_vld_o,
  output logic [31:0]     pt_z_o,
  output asg_pkg::quad_e  pt_quad_o,
  output asg_pkg::meta_t  pt_meta_o
);
  import asg_pkg::*;

  logic             busy_q;
  logic [IDX_W-1:0] idx_q;
  logic [ANG_W-1:0] ang_q;
  logic [REM_W-1:0] rem_q;
  job_t             job_q;

  logic             last;
  logic             load;
  logic [REM_W:0]   rsum;
  logic             carry;
  logic [REM_W-1:0] rem_n;
  logic [ANG_W:0]   step;
  logic [ANG_W:0]   up;
  logic [ANG_W:0]   dn;
  logic [ANG_W-1:0] ang_n;
  quad_e            quad;
  logic [ANG_W-1:0] resid;

  assign last      = (idx_q == IDX_W'(ARC_POINTS - 1));
  assign load      = job_valid_i && (!busy_q || last);
  assign job_pop_o = ce_i && load;

  always_comb begin
    // rounding remainder: a carry adds one more unit to this step
    rsum  = {1'b0, rem_q} + {1'b0, job_q.step_rem};
    carry = (rsum >= (REM_W+1)'(SEG_DEN));
    rem_n = carry ? REM_W'(rsum - (REM_W+1)'(SEG_DEN)) : rsum[REM_W-1:0];
    step  = {1'b0, job_q.step_ang} + (ANG_W+1)'(carry);
    up    = {1'b0, ang_q} + step;
    dn    = {1'b0, ang_q} - step;
    if (job_q.neg) begin
      ang_n = dn[ANG_W] ? ANG_W'(dn + {1'b0, DEG360_A}) : dn[ANG_W-1:0];
    end else begin
      ang_n = (up >= {1'b0, DEG360_A}) ? ANG_W'(up - {1'b0, DEG360_A}) : up[ANG_W-1:0];
    end
    if (ang_q < DEG90_A) begin
      quad  = QUAD_0;
      resid = ang_q;
    end else if (ang_q < DEG180_A) begin
      quad  = QUAD_1;
      resid = ang_q - DEG90_A;
    end else if (ang_q < DEG270_A) begin
      quad  = QUAD_2;
      resid = ang_q - DEG180_A;
    end else begin
      quad  = QUAD_3;
      resid = ang_q - DEG270_A;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      pt_vld_o <= 1'b0;
    end else if (ce_i) begin
      pt_vld_o <= busy_q;
      if (load) begin
        busy_q <= 1'b1;
      end else if (last) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      pt_z_o         <= {1'b0, resid[RES_W-1:0], 8'h00};
      pt_quad_o      <= quad;
      pt_meta_o.req  <= job_q.req;
      pt_meta_o.idx  <= idx_q;
      if (load) begin
        job_q <= job_i;
        idx_q <= '0;
        ang_q <= job_i.start_ang;
        rem_q <= REM_W'(SEG_DEN / 2);
      end else if (busy_q) begin
        idx_q <= idx_q + 1'b1;
        ang_q <= ang_n;
        rem_q <= rem_n;
      end
    end
  end

  `ASG_ASSERT(a_ang_range, busy_q |-> (ang_q < DEG360_A), "sweep angle outside one turn")
  `ASG_ASSERT(a_rem_range, busy_q |-> (rem_q < REM_W'(SEG_DEN)), "rounding remainder too large")
  `ASG_NEVER(a_pop_empty, job_pop_o && !job_valid_i, "job taken from empty queue")

endmodule

@@ rtl/core/asg_cordic.sv @@
// ----------------------------------------------------------------------------
// Arc segment generator CORDIC
// Rotation-mode pipeline, one iteration per stage, cos and sin in Q2.30.
// ----------------------------------------------------------------------------
module asg_cordic (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   ce_i,
  input  logic                   in_vld_i,
  input  logic [31:0]            in_z_i,
  input  asg_pkg::quad_e         in_quad_i,
  input  asg_pkg::meta_t         in_meta_i,
  output logic                   out_vld_o,
  output logic signed [31:0]     out_x_o,
  output logic signed [31:0]     out_y_o,
  output asg_pkg::quad_e         out_quad_o,
  output asg_pkg::meta_t         out_meta_o
);
  import asg_pkg::*;

  logic [CORDIC_ITERS-1:0] vld_q;
  logic signed [31:0]      x_q    [CORDIC_ITERS];
  logic signed [31:0]      y_q    [CORDIC_ITERS];
  logic signed [31:0]      z_q    [CORDIC_ITERS];
  quad_e                   quad_q [CORDIC_ITERS];
  meta_t                   meta_q [CORDIC_ITERS];

  for (genvar k = 0; k < CORDIC_ITERS; k++) begin : g_stage
    logic               vi;
    logic signed [31:0] xi;
    logic signed [31:0] yi;
    logic signed [31:0] zi;
    quad_e              qi;
    meta_t              mi;
    logic signed [31:0] xs;
    logic signed [31:0] ys;

    if (k == 0) begin : g_first
      assign vi = in_vld_i;
      assign xi = CORDIC_GAIN;
      assign yi = '0;
      assign zi = in_z_i;
      assign qi = in_quad_i;
      assign mi = in_meta_i;
    end else begin : g_next
      assign vi = vld_q[k-1];
      assign xi = x_q[k-1];
      assign yi = y_q[k-1];
      assign zi = z_q[k-1];
      assign qi = quad_q[k-1];
      assign mi = meta_q[k-1];
    end

    assign xs = xi >>> k;
    assign ys = yi >>> k;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (ce_i) begin
        vld_q[k] <= vi;
      end
    end

    // rotate toward zero residual angle
    always_ff @(posedge clk_i) begin
      if (ce_i) begin
        if (!zi[31]) begin
          x_q[k] <= xi - ys;
          y_q[k] <= yi + xs;
          z_q[k] <= zi - atan_q24(k);
        end else begin
          x_q[k] <= xi + ys;
          y_q[k] <= yi - xs;
          z_q[k] <= zi + atan_q24(k);
        end
        quad_q[k] <= qi;
        meta_q[k] <= mi;
      end
    end
  end

  assign out_vld_o  = vld_q[CORDIC_ITERS-1];
  assign out_x_o    = x_q[CORDIC_ITERS-1];
  assign out_y_o    = y_q[CORDIC_ITERS-1];
  assign out_quad_o = quad_q[CORDIC_ITERS-1];
  assign out_meta_o = meta_q[CORDIC_ITERS-1];

endmodule

@@ rtl/core/asg_emit.sv @@
// ----------------------------------------------------------------------------
// Arc segment generator back end
// Scales by radius, offsets by center, saturates and pairs points into segments.
// ----------------------------------------------------------------------------
module asg_emit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  output logic                        ce_o,
  input  logic                        in_vld_i,
  input  logic signed [31:0]          in_x_i,
  input  logic signed [31:0]          in_y_i,
  input  asg_pkg::quad_e              in_quad_i,
  input  asg_pkg::meta_t              in_meta_i,
  output logic                        m_tvalid_o,
  input  logic                        m_tready_i,
  output logic [asg_pkg::OUT_W-1:0]   m_tdata_o,
  output logic                        m_tlast_o
);
  import asg_pkg::*;

  localparam logic [65:0] ROUND_Q30 = 66'd1 << 29;

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] base,
                                                 input logic [65:0] rnd);
    logic [36:0] sum;
    sum = {{5{base[31]}}, base} + {rnd[65], rnd[65:30]};
    if (sum[36:31] == 6'b000000 || sum[36:31] == 6'b111111) begin
      return sum[31:0];
    end
    return sum[36] ? 32'sh8000_0000 : 32'sh7fff_ffff;
  endfunction

  logic               ce;
  logic signed [31:0] cs;
  logic signed [31:0] sn;

  logic               p1_vld_q;
  logic signed [64:0] p1_px_q;
  logic signed [64:0] p1_py_q;
  meta_t              p1_meta_q;

  logic               p2_vld_q;
  logic signed [31:0] p2_x_q;
  logic signed [31:0] p2_y_q;
  meta_t              p2_meta_q;

  logic signed [31:0] prev_x_q;
  logic signed [31:0] prev_y_q;

  logic [65:0]        rnd_x;
  logic [65:0]        rnd_y;
  logic               seg;

  // Whole back end advances together unless a result is waiting and not taken
  assign ce   = !m_tvalid_o || m_tready_i;
  assign ce_o = ce;

  always_comb begin
    case (in_quad_i)
      QUAD_0: begin cs = in_x_i;        sn = in_y_i;        end
      QUAD_1: begin cs = -in_y_i;       sn = in_x_i;        end
      QUAD_2: begin cs = -in_x_i;       sn = -in_y_i;       end
      QUAD_3: begin cs = in_y_i;        sn = -in_x_i;       end
      default: begin cs = in_x_i;       sn = in_y_i;        end
    endcase
    rnd_x = {p1_px_q[64], p1_px_q} + ROUND_Q30;
    rnd_y = {p1_py_q[64], p1_py_q} + ROUND_Q30;
    seg   = p2_vld_q && (p2_meta_q.idx != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_vld_q   <= 1'b0;
      p2_vld_q   <= 1'b0;
      m_tvalid_o <= 1'b0;
    end else if (ce) begin
      p1_vld_q   <= in_vld_i;
      p2_vld_q   <= p1_vld_q;
      m_tvalid_o <= seg;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      p1_px_q   <= $signed({1'b0, in_meta_i.req.radius}) * cs;
      p1_py_q   <= $signed({1'b0, in_meta_i.req.radius}) * sn;
      p1_meta_q <= in_meta_i;
      p2_x_q    <= sat_add(p1_meta_q.req.cx, rnd_x);
      p2_y_q    <= sat_add(p1_meta_q.req.cy, rnd_y);
      p2_meta_q <= p1_meta_q;
      if (p2_vld_q) begin
        prev_x_q <= p2_x_q;
        prev_y_q <= p2_y_q;
      end
      m_tdata_o <= {p2_meta_q.req.flag, p2_meta_q.req.param, p2_meta_q.req.color,
                    p2_meta_q.req.cz, p2_y_q, p2_x_q, prev_y_q, prev_x_q};
      m_tlast_o <= (p2_meta_q.idx == IDX_W'(ARC_POINTS - 1));
    end
  end

endmodule

@@ rtl/core/arc_segment_generator_top.sv @@
// ----------------------------------------------------------------------------
// Arc segment generator
// Lays 16 points on an arc with a CORDIC and streams the 15 joining segments.
// ----------------------------------------------------------------------------
// Path from request accept to the first segment: front end, queue, sweep, 24 CORDIC
//   stages, scale and offset registers, the wait for the second point, output register.
// The sweep issues one point per cycle into the CORDIC pipeline while the back end
//   advances; segments leave at one per cycle unless the output stalls.
// The front end takes no new request until its job is pushed into the queue.
// Reset clears all handshake and state registers; data registers and the point index keep content.
module arc_segment_generator_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // center_x, center_y, center_z, arc_radius, start_degrees, end_degrees,
  // line_color, line_param, line_flag (32 bits each, lowest first)
  input  logic [asg_pkg::IN_W-1:0]   s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // seg_start_x, seg_start_y, seg_end_x, seg_end_y, seg_z, seg_color,
  // seg_param, seg_flag (32 bits each, lowest first)
  output logic [asg_pkg::OUT_W-1:0]  m_axis_tdata,
  // last_segment
  output logic                       m_axis_tlast
);
  import asg_pkg::*;

  // front end to queue
  logic               fj_valid;
  logic               fj_ready;
  job_t               fj_job;

  // queue to sweep
  logic               qj_valid;
  logic               qj_pop;
  job_t               qj_job;

  // shared advance for the whole back end
  logic               ce;

  // sweep to CORDIC
  logic               sw_vld;
  logic [31:0]        sw_z;
  quad_e              sw_quad;
  meta_t              sw_meta;

  // CORDIC to output stages
  logic               cd_vld;
  logic signed [31:0] cd_x;
  logic signed [31:0] cd_y;
  quad_e              cd_quad;
  meta_t              cd_meta;

  // Fold the sweep, divide it by the segment count and reduce both angles
  asg_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_o  (s_axis_tready),
    .s_tdata_i   (s_axis_tdata),
    .job_valid_o (fj_valid),
    .job_ready_i (fj_ready),
    .job_o       (fj_job)
  );

  // Hold prepared jobs so the front end can run ahead of the sweep
  asg_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fj_valid),
    .push_ready_o (fj_ready),
    .push_job_i   (fj_job),
    .pop_valid_o  (qj_valid),
    .pop_i        (qj_pop),
    .pop_job_o    (qj_job)
  );

  // Advance the angle one point per cycle while the back end advances; next job starts right after the last point
  asg_sweep u_sweep (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ce_i        (ce),
    .job_valid_i (qj_valid),
    .job_i       (qj_job),
    .job_pop_o   (qj_pop),
    .pt_vld_o    (sw_vld),
    .pt_z_o      (sw_z),
    .pt_quad_o   (sw_quad),
    .pt_meta_o   (sw_meta)
  );

  asg_cordic u_cordic (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ce_i       (ce),
    .in_vld_i   (sw_vld),
    .in_z_i     (sw_z),
    .in_quad_i  (sw_quad),
    .in_meta_i  (sw_meta),
    .out_vld_o  (cd_vld),
    .out_x_o    (cd_x),
    .out_y_o    (cd_y),
    .out_quad_o (cd_quad),
    .out_meta_o (cd_meta)
  );

  // Scale, offset, saturate, pair consecutive points; drop the first point alone
  asg_emit u_emit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ce_o       (ce),
    .in_vld_i   (cd_vld),
    .in_x_i     (cd_x),
    .in_y_i     (cd_y),
    .in_quad_i  (cd_quad),
    .in_meta_i  (cd_meta),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_o  (m_axis_tdata),
    .m_tlast_o  (m_axis_tlast)
  );

endmodule
